// ----- rtl/core/ptk_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptk_pkg
// Shared constants and types of the PATRICIA trie key store.
// ----------------------------------------------------------------------------
package ptk_pkg;

  localparam int NODES_DEF    = 256;
  localparam int KEY_BITS_DEF = 32;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 2;
  localparam int PORT_KEY_W = 32;

  // Request operations
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  // Per-field write enables of the node memory
  typedef struct packed {
    logic key;
    logic nbit;
    logic left;
    logic right;
  } node_wen_t;

endpackage

// ----- rtl/core/ptk_node_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptk_node_mem
// Node memory (key, bit number, links) and free-list link memory.
// ----------------------------------------------------------------------------
module ptk_node_mem #(
  parameter int NODES    = ptk_pkg::NODES_DEF,
  parameter int KEY_BITS = ptk_pkg::KEY_BITS_DEF,
  localparam int IW = $clog2(NODES),
  localparam int CW = $clog2(NODES + 1),
  localparam int BW = $clog2(KEY_BITS + 1)
) (
  input  logic              clk,
  input  logic [IW-1:0]     rd_addr,
  output logic [KEY_BITS-1:0] rd_key,
  output logic [BW-1:0]     rd_bit,
  output logic [IW-1:0]     rd_left,
  output logic [IW-1:0]     rd_right,
  input  ptk_pkg::node_wen_t wen,
  input  logic [IW-1:0]     wr_addr,
  input  logic [KEY_BITS-1:0] wr_key,
  input  logic [BW-1:0]     wr_bit,
  input  logic [IW-1:0]     wr_left,
  input  logic [IW-1:0]     wr_right,
  input  logic [IW-1:0]     fl_rd_addr,
  output logic [CW-1:0]     fl_rd_data,
  input  logic              fl_we,
  input  logic [IW-1:0]     fl_wr_addr,
  input  logic [CW-1:0]     fl_wr_data
);

  logic [KEY_BITS-1:0] mem_key   [NODES];
  logic [BW-1:0]       mem_bit   [NODES];
  logic [IW-1:0]       mem_left  [NODES];
  logic [IW-1:0]       mem_right [NODES];
  logic [CW-1:0]       mem_free  [NODES];

  always_ff @(posedge clk) begin
    if (wen.key)   mem_key[wr_addr]   <= wr_key;
    if (wen.nbit)  mem_bit[wr_addr]   <= wr_bit;
    if (wen.left)  mem_left[wr_addr]  <= wr_left;
    if (wen.right) mem_right[wr_addr] <= wr_right;
    rd_key   <= mem_key[rd_addr];
    rd_bit   <= mem_bit[rd_addr];
    rd_left  <= mem_left[rd_addr];
    rd_right <= mem_right[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (fl_we) mem_free[fl_wr_addr] <= fl_wr_data;
    fl_rd_data <= mem_free[fl_rd_addr];
  end

endmodule

// ----- rtl/core/ptk_diff.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptk_diff
// Serial first-difference finder, eight key bits per cycle, MSB is bit 1.
// ----------------------------------------------------------------------------
module ptk_diff #(
  parameter int KEY_BITS = ptk_pkg::KEY_BITS_DEF,
  localparam int BW = $clog2(KEY_BITS + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [KEY_BITS-1:0] a,
  input  logic [KEY_BITS-1:0] b,
  output logic                done,
  output logic [BW-1:0]       d
);

  localparam int PW   = ((KEY_BITS + 7) / 8) * 8;
  localparam int CNTW = $clog2(PW + 1);

  logic [PW-1:0]   sh_r;
  logic [CNTW-1:0] base_r;
  logic            run_r;
  logic [7:0]      top;
  logic [2:0]      lz;
  logic            hit;

  assign top = sh_r[PW-1 -: 8];

  always_comb begin
    lz  = '0;
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!hit && top[7-i]) begin
        hit = 1'b1;
        lz  = 3'(i);
      end
    end
  end

  assign done = run_r && hit;
  assign d    = BW'(int'(base_r) + int'(lz) + 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
    end else if (start) begin
      run_r <= 1'b1;
    end else if (done) begin
      run_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r   <= PW'(a ^ b) << (PW - KEY_BITS);
      base_r <= '0;
    end else if (run_r && !hit) begin
      sh_r   <= sh_r << 8;
      base_r <= base_r + CNTW'(8);
    end
  end

endmodule

// ----- rtl/core/ptk_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptk_ctrl
// Sequencer: walks the trie one node read per cycle, then writes back for inserts and deletes.
// ----------------------------------------------------------------------------
module ptk_ctrl #(
  parameter int NODES    = ptk_pkg::NODES_DEF,
  parameter int KEY_BITS = ptk_pkg::KEY_BITS_DEF,
  localparam int IW = $clog2(NODES),
  localparam int CW = $clog2(NODES + 1),
  localparam int BW = $clog2(KEY_BITS + 1)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ptk_pkg::FUNC_W-1:0]    func,
  input  logic [KEY_BITS-1:0]           key,
  output logic                          idle,
  output logic                          res_valid,
  input  logic                          res_take,
  output logic [ptk_pkg::STATUS_W-1:0]  res_status,
  output logic [KEY_BITS-1:0]           res_key,
  output logic [IW-1:0]                 rd_addr,
  input  logic [KEY_BITS-1:0]           rd_key,
  input  logic [BW-1:0]                 rd_bit,
  input  logic [IW-1:0]                 rd_left,
  input  logic [IW-1:0]                 rd_right,
  output ptk_pkg::node_wen_t            wen,
  output logic [IW-1:0]                 wr_addr,
  output logic [KEY_BITS-1:0]           wr_key,
  output logic [BW-1:0]                 wr_bit,
  output logic [IW-1:0]                 wr_left,
  output logic [IW-1:0]                 wr_right,
  output logic [IW-1:0]                 fl_rd_addr,
  input  logic [CW-1:0]                 fl_rd_data,
  output logic                          fl_we,
  output logic [IW-1:0]                 fl_wr_addr,
  output logic [CW-1:0]                 fl_wr_data,
  output logic                          diff_start,
  input  logic                          diff_done,
  input  logic [BW-1:0]                 diff_d
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ROOT  = 4'd1;
  localparam logic [3:0] S_WALK  = 4'd2;
  localparam logic [3:0] S_DIFF  = 4'd3;
  localparam logic [3:0] S_IHEAD = 4'd4;
  localparam logic [3:0] S_IWALK = 4'd5;
  localparam logic [3:0] S_ILINK = 4'd6;
  localparam logic [3:0] S_DCUR  = 4'd7;
  localparam logic [3:0] S_DCH   = 4'd8;
  localparam logic [3:0] S_DSC   = 4'd9;
  localparam logic [3:0] S_DSCL  = 4'd10;
  localparam logic [3:0] S_DPAR  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  function automatic logic bit_at(input logic [KEY_BITS-1:0] k, input logic [BW-1:0] i);
    logic [KEY_BITS-1:0] sh;
    sh = k >> (KEY_BITS - int'(i));
    if (i == '0 || int'(i) > KEY_BITS) return 1'b0;
    return sh[0];
  endfunction

  logic [3:0]                  state_r;
  logic                        present_r;
  logic [IW-1:0]               head_r;
  logic [CW-1:0]               free_head_r;
  logic [CW-1:0]               fresh_r;

  logic [ptk_pkg::FUNC_W-1:0]  func_r;
  logic [KEY_BITS-1:0]         key_r;
  logic [BW-1:0]               d_r;
  logic [IW-1:0]               nw_r;
  logic [ptk_pkg::STATUS_W-1:0] status_r;
  logic [KEY_BITS-1:0]         rkey_r;
  logic [IW-1:0]               cur_idx_r, cur_left_r, cur_right_r;
  logic [BW-1:0]               cur_bit_r;
  logic [KEY_BITS-1:0]         cur_key_r;
  logic [IW-1:0]               par_idx_r, par_left_r;
  logic [BW-1:0]               par_bit_r;
  logic [IW-1:0]               ch_idx_r;
  logic [IW-1:0]               sc_idx_r, sc_left_r, sch_idx_r;
  logic [BW-1:0]               sc_bit_r;

  logic          fh_ok, fr_ok, full;
  logic [IW-1:0] take_idx;
  logic [IW-1:0] fol_k, fol_m, fol_c;
  logic          walk_more, iw_more, sc_more, key_eq, new_bit;
  logic [IW-1:0] other;

  assign fh_ok    = free_head_r < CW'(NODES);
  assign fr_ok    = fresh_r < CW'(NODES);
  assign full     = !fh_ok && !fr_ok;
  assign take_idx = fh_ok ? free_head_r[IW-1:0] : fresh_r[IW-1:0];

  assign fol_k = bit_at(key_r, rd_bit) ? rd_right : rd_left;
  assign fol_m = bit_at(cur_key_r, rd_bit) ? rd_right : rd_left;
  assign fol_c = bit_at(cur_key_r, cur_bit_r) ? cur_right_r : cur_left_r;

  assign walk_more = rd_bit > cur_bit_r;
  assign iw_more   = (rd_bit > par_bit_r) && (rd_bit < d_r);
  assign sc_more   = sc_bit_r < rd_bit;
  assign key_eq    = rd_key == key_r;
  assign new_bit   = bit_at(key_r, d_r);
  assign other     = (ch_idx_r == cur_left_r) ? cur_right_r : cur_left_r;

  assign idle       = state_r == S_IDLE;
  assign res_valid  = state_r == S_DONE;
  assign res_status = status_r;
  assign res_key    = rkey_r;
  assign fl_rd_addr = free_head_r[IW-1:0];

  // Memory addressing and write-back
  always_comb begin
    rd_addr    = head_r;
    wen        = '0;
    wr_addr    = nw_r;
    wr_key     = key_r;
    wr_bit     = d_r;
    wr_left    = nw_r;
    wr_right   = nw_r;
    fl_we      = 1'b0;
    fl_wr_addr = cur_idx_r;
    fl_wr_data = free_head_r;
    diff_start = 1'b0;
    unique case (state_r)
      S_ROOT: begin
        rd_addr = rd_left;
        if (!present_r && func_r == ptk_pkg::FUNC_INSERT && !full) begin
          wen      = '1;
          wr_addr  = take_idx;
          wr_bit   = '0;
          wr_left  = take_idx;
          wr_right = take_idx;
        end
        if (present_r && func_r == ptk_pkg::FUNC_DELETE && rd_left == head_r && key_eq) begin
          fl_we      = 1'b1;
          fl_wr_addr = head_r;
        end
      end
      S_WALK: begin
        rd_addr = fol_k;
        diff_start = !walk_more && func_r == ptk_pkg::FUNC_INSERT && !key_eq && !full;
      end
      S_IHEAD: rd_addr = rd_left;
      S_IWALK: begin
        rd_addr = fol_k;
        if (!iw_more) begin
          wen      = '1;
          wr_left  = new_bit ? cur_idx_r : nw_r;
          wr_right = new_bit ? nw_r : cur_idx_r;
        end
      end
      S_ILINK: begin
        wr_addr  = par_idx_r;
        wr_left  = nw_r;
        wr_right = nw_r;
        if (cur_idx_r == par_left_r) wen.left = 1'b1;
        else wen.right = 1'b1;
      end
      S_DCUR: rd_addr = fol_k;
      S_DCH: rd_addr = walk_more ? fol_k : fol_c;
      S_DSC: begin
        rd_addr = fol_m;
        if (!sc_more) begin
          wen.key = 1'b1;
          wr_addr = ch_idx_r;
          wr_key  = cur_key_r;
        end
      end
      S_DSCL: begin
        wr_addr  = sc_idx_r;
        wr_left  = ch_idx_r;
        wr_right = ch_idx_r;
        if (sch_idx_r == sc_left_r) wen.left = 1'b1;
        else wen.right = 1'b1;
      end
      S_DPAR: begin
        wr_addr  = par_idx_r;
        wr_left  = other;
        wr_right = other;
        if (cur_idx_r == par_left_r) wen.left = 1'b1;
        else wen.right = 1'b1;
        fl_we = 1'b1;
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      present_r   <= 1'b0;
      head_r      <= '0;
      free_head_r <= CW'(NODES);
      fresh_r     <= '0;
    end else begin
      unique case (state_r)
        S_IDLE: if (start) state_r <= S_ROOT;
        S_ROOT: begin
          state_r <= S_DONE;
          if (func_r == ptk_pkg::FUNC_INSERT && !present_r && !full) begin
            head_r    <= take_idx;
            present_r <= 1'b1;
            if (fh_ok) free_head_r <= fl_rd_data;
            else fresh_r <= fresh_r + 1'b1;
          end else if (present_r && (func_r == ptk_pkg::FUNC_SEARCH ||
                                     func_r == ptk_pkg::FUNC_INSERT)) begin
            state_r <= S_WALK;
          end else if (present_r && func_r == ptk_pkg::FUNC_DELETE) begin
            if (rd_left != head_r) begin
              state_r <= S_DCUR;
            end else if (key_eq) begin
              free_head_r <= CW'(head_r);
              present_r   <= 1'b0;
            end
          end
        end
        S_WALK: begin
          if (!walk_more) state_r <= diff_start ? S_DIFF : S_DONE;
        end
        S_DIFF:  if (diff_done) state_r <= S_IHEAD;
        S_IHEAD: state_r <= S_IWALK;
        S_IWALK: if (!iw_more) state_r <= S_ILINK;
        S_ILINK: begin
          state_r <= S_DONE;
          if (fh_ok) free_head_r <= fl_rd_data;
          else fresh_r <= fresh_r + 1'b1;
        end
        S_DCUR: state_r <= S_DCH;
        S_DCH:  if (!walk_more) state_r <= key_eq ? S_DSC : S_DONE;
        S_DSC:  if (!sc_more) state_r <= S_DSCL;
        S_DSCL: state_r <= S_DPAR;
        S_DPAR: begin
          state_r     <= S_DONE;
          free_head_r <= CW'(cur_idx_r);
        end
        S_DONE: if (res_take) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        func_r   <= func;
        key_r    <= key;
        status_r <= ptk_pkg::ST_MISS;
        rkey_r   <= '0;
      end
      S_ROOT: begin
        cur_bit_r   <= rd_bit;
        par_idx_r   <= head_r;
        par_bit_r   <= rd_bit;
        par_left_r  <= rd_left;
        cur_idx_r   <= rd_left;
        if (func_r == ptk_pkg::FUNC_INSERT && !present_r) begin
          status_r <= full ? ptk_pkg::ST_FULL : ptk_pkg::ST_OK;
        end
        if (func_r == ptk_pkg::FUNC_DELETE && present_r && rd_left == head_r && key_eq) begin
          status_r <= ptk_pkg::ST_OK;
        end
      end
      S_WALK: begin
        cur_bit_r <= rd_bit;
        if (!walk_more) begin
          nw_r <= take_idx;
          if (func_r == ptk_pkg::FUNC_SEARCH) begin
            rkey_r   <= rd_key;
            status_r <= key_eq ? ptk_pkg::ST_OK : ptk_pkg::ST_MISS;
          end else begin
            status_r <= key_eq ? ptk_pkg::ST_DUP :
                        full   ? ptk_pkg::ST_FULL : ptk_pkg::ST_OK;
          end
        end
      end
      S_DIFF: if (diff_done) d_r <= diff_d;
      S_IHEAD: begin
        par_idx_r   <= head_r;
        par_bit_r   <= rd_bit;
        par_left_r  <= rd_left;
        cur_idx_r   <= rd_left;
      end
      S_IWALK: begin
        if (iw_more) begin
          par_idx_r   <= cur_idx_r;
          par_bit_r   <= rd_bit;
          par_left_r  <= rd_left;
          cur_idx_r   <= fol_k;
        end
      end
      S_DCUR: begin
        cur_bit_r   <= rd_bit;
        cur_left_r  <= rd_left;
        cur_right_r <= rd_right;
        cur_key_r   <= rd_key;
        ch_idx_r    <= fol_k;
      end
      S_DCH: begin
        if (walk_more) begin
          par_idx_r   <= cur_idx_r;
          par_bit_r   <= cur_bit_r;
          par_left_r  <= cur_left_r;
          cur_idx_r   <= ch_idx_r;
          cur_bit_r   <= rd_bit;
          cur_left_r  <= rd_left;
          cur_right_r <= rd_right;
          cur_key_r   <= rd_key;
          ch_idx_r    <= fol_k;
        end else begin
          sc_idx_r   <= cur_idx_r;
          sc_bit_r   <= cur_bit_r;
          sc_left_r  <= cur_left_r;
          sch_idx_r  <= fol_c;
          status_r   <= key_eq ? ptk_pkg::ST_OK : ptk_pkg::ST_MISS;
        end
      end
      S_DSC: begin
        if (sc_more) begin
          sc_idx_r   <= sch_idx_r;
          sc_bit_r   <= rd_bit;
          sc_left_r  <= rd_left;
          sch_idx_r  <= fol_m;
        end
      end
      S_DSCL: begin
        // keep held copies of cur and par in step with the link just rewritten
        if (sc_idx_r == cur_idx_r) begin
          if (sch_idx_r == sc_left_r) cur_left_r <= ch_idx_r;
          else cur_right_r <= ch_idx_r;
        end
        if (sc_idx_r == par_idx_r && sch_idx_r == sc_left_r) begin
          par_left_r <= ch_idx_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/core/patricia_trie_key_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// patricia_trie_key_store
// Key store kept as a PATRICIA trie with a header node in a node memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, in_func, in_key): one request per
//   item, search (0), insert (1) or delete (2). Result channel (out_valid /
//   out_stall, out_status, out_reached_key): exactly one result per request,
//   in request order.
//   Each trie level costs one node memory read, through the single read
//   port of the node memory. A search walks the trie once; an insert walks
//   it twice with a first-difference scan between, and a delete walks
//   twice. One request is in work at a time; in_stall is high while it is.
//   Reset: the trie is empty, the free list empty and no node is used. The
//   node memory needs no clearing pass.
//   Stall: a finished result sits in the output register while out_stall is
//   high; the next request is taken meanwhile and completes into the
//   register once it frees up.
// ----------------------------------------------------------------------------
module patricia_trie_key_store #(
  parameter int NODES    = ptk_pkg::NODES_DEF,
  parameter int KEY_BITS = ptk_pkg::KEY_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ptk_pkg::FUNC_W-1:0]     in_func,
  input  logic [ptk_pkg::PORT_KEY_W-1:0] in_key,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ptk_pkg::STATUS_W-1:0]   out_status,
  output logic [ptk_pkg::PORT_KEY_W-1:0] out_reached_key
);

  localparam int IW = $clog2(NODES);
  localparam int CW = $clog2(NODES + 1);
  localparam int BW = $clog2(KEY_BITS + 1);

  logic                          idle;
  logic                          accept;
  logic [63:0]                   key_wide;
  logic [KEY_BITS-1:0]           key_in;
  logic                          res_valid;
  logic                          res_take;
  logic [ptk_pkg::STATUS_W-1:0]  res_status;
  logic [KEY_BITS-1:0]           res_key;
  logic [63:0]                   res_key_wide;

  logic [IW-1:0]                 rd_addr;
  logic [KEY_BITS-1:0]           rd_key;
  logic [BW-1:0]                 rd_bit;
  logic [IW-1:0]                 rd_left, rd_right;
  ptk_pkg::node_wen_t            wen;
  logic [IW-1:0]                 wr_addr;
  logic [KEY_BITS-1:0]           wr_key;
  logic [BW-1:0]                 wr_bit;
  logic [IW-1:0]                 wr_left, wr_right;
  logic [IW-1:0]                 fl_rd_addr;
  logic [CW-1:0]                 fl_rd_data;
  logic                          fl_we;
  logic [IW-1:0]                 fl_wr_addr;
  logic [CW-1:0]                 fl_wr_data;
  logic                          diff_start, diff_done;
  logic [BW-1:0]                 diff_d;

  logic                          out_valid_r;
  logic [ptk_pkg::STATUS_W-1:0]  out_status_r;
  logic [ptk_pkg::PORT_KEY_W-1:0] out_key_r;

  // Take one request only while the sequencer sits idle.
  assign in_stall = !idle;
  assign accept   = in_valid && !in_stall;

  // Keep only the low KEY_BITS bits of the incoming key.
  assign key_wide = 64'(in_key);
  assign key_in   = key_wide[KEY_BITS-1:0];

  ptk_ctrl #(.NODES(NODES), .KEY_BITS(KEY_BITS)) u_ctrl (
    .clk, .rst_n,
    .start(accept), .func(in_func), .key(key_in),
    .idle, .res_valid, .res_take, .res_status, .res_key,
    .rd_addr, .rd_key, .rd_bit, .rd_left, .rd_right,
    .wen, .wr_addr, .wr_key, .wr_bit, .wr_left, .wr_right,
    .fl_rd_addr, .fl_rd_data, .fl_we, .fl_wr_addr, .fl_wr_data,
    .diff_start, .diff_done, .diff_d
  );

  ptk_node_mem #(.NODES(NODES), .KEY_BITS(KEY_BITS)) u_mem (
    .clk,
    .rd_addr, .rd_key, .rd_bit, .rd_left, .rd_right,
    .wen, .wr_addr, .wr_key, .wr_bit, .wr_left, .wr_right,
    .fl_rd_addr, .fl_rd_data, .fl_we, .fl_wr_addr, .fl_wr_data
  );

  // The diff unit compares the request key against the key the walk reached;
  // the request key is the insert key held in the write data path.
  ptk_diff #(.KEY_BITS(KEY_BITS)) u_diff (
    .clk, .rst_n,
    .start(diff_start), .a(wr_key), .b(rd_key),
    .done(diff_done), .d(diff_d)
  );

  // Output register: load a finished result when the register is empty or
  // being drained this cycle.
  assign res_take     = res_valid && (!out_valid_r || !out_stall);
  assign res_key_wide = 64'(res_key);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_status_r <= res_status;
      out_key_r    <= res_key_wide[ptk_pkg::PORT_KEY_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_reached_key = out_key_r;

  // A request is never taken in the cycle its predecessor's result completes.
  assert property (@(posedge clk) disable iff (!rst_n) res_take |-> !accept)
    else $error("request accepted while a result completes");

  // After a request is taken the block is busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n) accept |=> in_stall)
    else $error("block not busy after accept");

  // Duplicate and full results come from inserts, which report no key.
  assert property (@(posedge clk) disable iff (!rst_n)
    res_take && (res_status == ptk_pkg::ST_DUP || res_status == ptk_pkg::ST_FULL)
      |-> res_key == '0)
    else $error("insert result carries a reached key");

  // The diff unit only runs during an insert, never once the result is out.
  assert property (@(posedge clk) disable iff (!rst_n) diff_start |=> !res_valid)
    else $error("diff started at end of request");

endmodule
